### rtl/pfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants of the perspective floor sampler.
// ----------------------------------------------------------------------------
package pfs_pkg;

  // Texture, screen and fixed-point constants
  localparam int TEX_SIZE    = 1024;
  localparam int MAX_SCREEN  = 1024;
  localparam int SKY_WRAP    = 1022;
  localparam int FRAC_BITS   = 8;
  localparam int QUARTER     = 16384;
  localparam int TRIG_FRAC   = 14;

  // Sine polynomial coefficients
  localparam int SIN_C1 = 10583;
  localparam int SIN_C2 = 1306;
  localparam int SIN_C3 = 25736;

  // Field and register widths
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int SCREEN_W    = 11;
  localparam int PIXEL_X_W   = 10;
  localparam int PIXEL_ROW_W = 9;
  localparam int TEX_W       = 10;
  localparam int CORNER_W    = 24;
  localparam int NUM_CORNERS = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_HEADING,
    REG_HALF_FOV,
    REG_NEAR_DIST,
    REG_FAR_DIST,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT
  } cfg_reg_t;

  // Corner sequencer states
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MUL,
    CS_STORE
  } corner_state_t;

  typedef logic signed [CORNER_W-1:0] corner_t;

  // Camera settings handed to the corner unit
  typedef struct packed {
    logic signed [19:0] camera_x;
    logic signed [19:0] camera_y;
    logic [15:0]        heading;
    logic [13:0]        half_fov;
    logic [19:0]        near_dist;
    logic [19:0]        far_dist;
  } cam_cfg_t;

endpackage

### rtl/perspective_floor_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_floor_sampler
// Perspective floor and sky texel coordinates for one screen pixel per item.
// ----------------------------------------------------------------------------
// One item per clock cycle. The pipeline is four setup stages, a 32-stage
// row-depth divider, five interpolation stages, a 44-stage divider by the
// screen width, three stages, two stages that wrap by 1022 through a digit
// sum by 511, and the output register. The whole pipeline holds together
// while a result is not taken. Each configuration write restarts the corner
// sequencer, which runs on one shared multiplier; in_ready stays low until
// it finishes.
module perspective_floor_sampler import pfs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PIXEL_X_W-1:0]   pixel_x,
  input  logic [PIXEL_ROW_W-1:0] pixel_row,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TEX_W-1:0]       floor_u,
  output logic [TEX_W-1:0]       floor_v,
  output logic                   floor_outside,
  output logic [TEX_W-1:0]       sky_u,
  output logic [TEX_W-1:0]       sky_v
);

  localparam int DIFF_W = CORNER_W + 1;
  localparam int P2_W   = DIFF_W + SCREEN_W + 1;
  localparam int NB1    = 32;
  localparam int DB1    = PIXEL_ROW_W + 1;
  localparam int RP_W   = NB1 + 1;
  localparam int D2_W   = RP_W + 1;
  localparam int P7_W   = D2_W + PIXEL_X_W + 1;
  localparam int NB2    = P7_W - 1;
  localparam int DB2    = SCREEN_W;
  localparam int Q2_W   = NB2 + 1;
  localparam int SX_W   = NB2 + 2;
  localparam int NB3    = SX_W - FRAC_BITS;
  localparam int DB3    = 10;
  localparam int PW1    = PIXEL_X_W + 1 + 4;
  localparam int PW2    = 2 * RP_W + 3;
  localparam int PW3    = 2 * TEX_W + 3 + 2 * FRAC_BITS;
  localparam int M_W    = DB3 + FRAC_BITS;
  localparam logic signed [SX_W-1:0] TEX_LIM = SX_W'(TEX_SIZE) <<< FRAC_BITS;
  // 511 is one less than 2**9, so 9 bit digits of a value sum to it mod 511
  localparam int WRAP_HALF = SKY_WRAP / 2;
  localparam int DIG_N     = (NB3 - 1 + 8) / 9;
  localparam int DIG_W     = DIG_N * 9;
  localparam int DSUM_W    = 12;

  cam_cfg_t            cfg;
  logic [SCREEN_W-1:0] screen_width, screen_height;
  logic                busy;
  corner_t             corners [NUM_CORNERS];
  logic                en, accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_x  <= '0;
      cfg.camera_y  <= '0;
      cfg.heading   <= '0;
      cfg.half_fov  <= 14'd8192;
      cfg.near_dist <= '0;
      cfg.far_dist  <= '0;
      screen_width  <= 11'(MAX_SCREEN);
      screen_height <= 11'(MAX_SCREEN);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAMERA_X:  cfg.camera_x  <= $signed(cfg_data[19:0]);
        REG_CAMERA_Y:  cfg.camera_y  <= $signed(cfg_data[19:0]);
        REG_HEADING:   cfg.heading   <= cfg_data[15:0];
        REG_HALF_FOV:  cfg.half_fov  <= cfg_data[13:0];
        REG_NEAR_DIST: cfg.near_dist <= cfg_data[19:0];
        REG_FAR_DIST:  cfg.far_dist  <= cfg_data[19:0];
        REG_SCREEN_WIDTH:
          screen_width <= (cfg_data[10:0] > 11'(MAX_SCREEN)) ? 11'(MAX_SCREEN)
                                                              : cfg_data[10:0];
        REG_SCREEN_HEIGHT:
          screen_height <= (cfg_data[10:0] > 11'(MAX_SCREEN)) ? 11'(MAX_SCREEN)
                                                               : cfg_data[10:0];
      endcase
    end
  end

  pfs_corner u_corner (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_we),
    .cfg     (cfg),
    .busy    (busy),
    .corners (corners)
  );

  // Stall everything when the result is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !busy && !cfg_we;
  assign accept   = in_valid && in_ready;

  // S0: capture the item
  logic                   v0;
  logic [PIXEL_X_W-1:0]   px0;
  logic [PIXEL_ROW_W-1:0] row0;
  // S1: far minus near
  logic                   v1;
  logic [PIXEL_X_W-1:0]   px1;
  logic [PIXEL_ROW_W-1:0] row1;
  logic signed [DIFF_W-1:0] d1 [4];
  // S2: scale by height
  logic                   v2;
  logic [PIXEL_X_W-1:0]   px2;
  logic [PIXEL_ROW_W-1:0] row2;
  logic signed [P2_W-1:0] p2 [4];
  // S3: magnitude and divisor
  logic                   v3;
  logic [3:0][NB1-1:0]    mag3;
  logic [3:0]             sgn3;
  logic [DB1-1:0]         den3;
  logic                   rz3;
  logic [PIXEL_X_W-1:0]   px3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px0  <= pixel_x;
      row0 <= pixel_row;
      px1  <= px0;
      row1 <= row0;
      px2  <= px1;
      row2 <= row1;
      px3  <= px2;
      rz3  <= (row2 == '0);
      den3 <= (row2 == '0) ? DB1'(1) : {row2, 1'b0};
      for (int l = 0; l < 4; l++) begin
        d1[l]   <= DIFF_W'(corners[(l >> 1) * 4 + (l & 1)]) -
                   DIFF_W'(corners[(l >> 1) * 4 + (l & 1) + 2]);
        p2[l]   <= d1[l] * $signed({1'b0, screen_height});
        sgn3[l] <= p2[l][P2_W-1];
        mag3[l] <= p2[l][P2_W-1] ? NB1'(-p2[l]) : NB1'(p2[l]);
      end
    end
  end

  // Row depth division by twice the row
  logic                 v_d1;
  logic [3:0][NB1-1:0]  q1;
  logic [3:0][DB1-1:0]  r1_unused;
  logic [PW1-1:0]       pay1;
  logic [PIXEL_X_W-1:0] px_d1;
  logic                 rz_d1;
  logic [3:0]           sgn_d1;

  pfs_div #(.NB(NB1), .DB(DB1), .LANES(4), .PW(PW1)) u_div_row (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_num    (mag3),
    .in_den    (den3),
    .in_pay    ({px3, rz3, sgn3}),
    .out_valid (v_d1),
    .out_quo   (q1),
    .out_rem   (r1_unused),
    .out_pay   (pay1)
  );

  assign {px_d1, rz_d1, sgn_d1} = pay1;

  // S4..S8: row end points, span and interpolation numerator
  logic                   v4, v5, v6, v7, v8;
  logic signed [RP_W-1:0] qs4 [4];
  logic                   rz4;
  logic [PIXEL_X_W-1:0]   px4, px5, px6;
  logic signed [RP_W-1:0] rp5 [4];
  logic signed [D2_W-1:0] dx6, dy6;
  logic signed [RP_W-1:0] sx6, sy6, sx7, sy7, sx8, sy8;
  logic signed [P7_W-1:0] p7x, p7y;
  logic [1:0][NB2-1:0]    mag8;
  logic [1:0]             sgn8;
  logic [DB2-1:0]         den8;
  logic                   wz8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v4 <= v_d1;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rz4 <= rz_d1;
      px4 <= px_d1;
      px5 <= px4;
      for (int l = 0; l < 4; l++) begin
        qs4[l] <= sgn_d1[l] ? -$signed({1'b0, q1[l]}) : $signed({1'b0, q1[l]});
        rp5[l] <= rz4 ? RP_W'(corners[(l >> 1) * 4 + (l & 1)])
                      : RP_W'(corners[(l >> 1) * 4 + (l & 1) + 2]) + qs4[l];
      end
      dx6  <= D2_W'(rp5[2]) - D2_W'(rp5[0]);
      dy6  <= D2_W'(rp5[3]) - D2_W'(rp5[1]);
      sx6  <= rp5[0];
      sy6  <= rp5[1];
      px6  <= px5;
      p7x  <= dx6 * $signed({1'b0, px6});
      p7y  <= dy6 * $signed({1'b0, px6});
      sx7  <= sx6;
      sy7  <= sy6;
      sgn8 <= {p7y[P7_W-1], p7x[P7_W-1]};
      mag8[0] <= p7x[P7_W-1] ? NB2'(-p7x) : NB2'(p7x);
      mag8[1] <= p7y[P7_W-1] ? NB2'(-p7y) : NB2'(p7y);
      wz8  <= (screen_width == '0);
      den8 <= (screen_width == '0) ? DB2'(1) : screen_width;
      sx8  <= sx7;
      sy8  <= sy7;
    end
  end

  // Interpolation division by the screen width
  logic                   v_d2;
  logic [1:0][NB2-1:0]    q2;
  logic [1:0][DB2-1:0]    r2_unused;
  logic [PW2-1:0]         pay2;
  logic signed [RP_W-1:0] sx_d2, sy_d2;
  logic [1:0]             sgn_d2;
  logic                   wz_d2;

  pfs_div #(.NB(NB2), .DB(DB2), .LANES(2), .PW(PW2)) u_div_width (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .in_num    (mag8),
    .in_den    (den8),
    .in_pay    ({sx8, sy8, sgn8, wz8}),
    .out_valid (v_d2),
    .out_quo   (q2),
    .out_rem   (r2_unused),
    .out_pay   (pay2)
  );

  assign {sx_d2, sy_d2, sgn_d2, wz_d2} = pay2;

  // S9..S11: sample point, floor texel and sky magnitudes
  logic                   v9, v10, v11;
  logic signed [Q2_W-1:0] qs9x, qs9y;
  logic signed [RP_W-1:0] sx9, sy9;
  logic                   wz9;
  logic signed [SX_W-1:0] sx10, sy10;
  logic                   neg_x, neg_y, outside;
  logic [SX_W-1:0]        ax, ay;
  logic [1:0][NB3-1:0]    mag11;
  logic [PW3-1:0]         pay11;

  always_comb begin
    neg_x   = sx10[SX_W-1];
    neg_y   = sy10[SX_W-1];
    ax      = neg_x ? SX_W'(-sx10) : SX_W'(sx10);
    ay      = neg_y ? SX_W'(-sy10) : SX_W'(sy10);
    outside = neg_x || neg_y || (sx10 >= TEX_LIM) || (sy10 >= TEX_LIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
    end else if (en) begin
      v9  <= v_d2;
      v10 <= v9;
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs9x  <= sgn_d2[0] ? -$signed({1'b0, q2[0]}) : $signed({1'b0, q2[0]});
      qs9y  <= sgn_d2[1] ? -$signed({1'b0, q2[1]}) : $signed({1'b0, q2[1]});
      sx9   <= sx_d2;
      sy9   <= sy_d2;
      wz9   <= wz_d2;
      sx10  <= wz9 ? SX_W'(sx9) : SX_W'(sx9) + SX_W'(qs9x);
      sy10  <= wz9 ? SX_W'(sy9) : SX_W'(sy9) + SX_W'(qs9y);
      mag11[0] <= ax[SX_W-1:FRAC_BITS];
      mag11[1] <= ay[SX_W-1:FRAC_BITS];
      pay11 <= {outside ? TEX_W'(0) : sx10[FRAC_BITS +: TEX_W],
                outside ? TEX_W'(0) : sy10[FRAC_BITS +: TEX_W],
                outside, neg_x, neg_y,
                ax[FRAC_BITS-1:0], ay[FRAC_BITS-1:0]};
    end
  end

  // Sky wrap: remainder by 1022 texels is twice the remainder of the upper
  // bits by 511, plus the low bit
  logic                   v12, v_d3;
  logic [1:0][DSUM_W-1:0] dsum, dsum12;
  logic [1:0]             odd12;
  logic [PW3-1:0]         pay12;
  logic [1:0][8:0]        fold;
  logic [1:0][DB3-1:0]    r3;
  logic [PW3-1:0]         pay3;
  logic [TEX_W-1:0]       fu_d3, fv_d3;
  logic                   out_d3, negx_d3, negy_d3;
  logic [FRAC_BITS-1:0]   fx_d3, fy_d3;

  // Sum the 9 bit digits of the upper bits
  always_comb begin
    logic [DIG_W-1:0] hv;
    hv = '0;
    for (int l = 0; l < 2; l++) begin
      hv      = DIG_W'(mag11[l][NB3-1:1]);
      dsum[l] = '0;
      for (int d = 0; d < DIG_N; d++) begin
        dsum[l] = dsum[l] + DSUM_W'(hv[d*9 +: 9]);
      end
    end
  end

  // Fold the digit sum once more and drop one 511
  always_comb begin
    logic [9:0] f;
    f = '0;
    for (int l = 0; l < 2; l++) begin
      f       = 10'(dsum12[l][8:0]) + 10'(dsum12[l][DSUM_W-1:9]);
      fold[l] = (f >= 10'(WRAP_HALF)) ? 9'(f - 10'(WRAP_HALF)) : f[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v12  <= 1'b0;
      v_d3 <= 1'b0;
    end else if (en) begin
      v12  <= v11;
      v_d3 <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsum12 <= dsum;
      odd12  <= {mag11[1][0], mag11[0][0]};
      pay12  <= pay11;
      r3[0]  <= {fold[0], odd12[0]};
      r3[1]  <= {fold[1], odd12[1]};
      pay3   <= pay12;
    end
  end

  assign {fu_d3, fv_d3, out_d3, negx_d3, negy_d3, fx_d3, fy_d3} = pay3;

  // Offset by one texel, take the magnitude, drop the fraction
  logic signed [M_W+1:0] wx, wy;
  logic [M_W+1:0]        awx, awy;

  always_comb begin
    logic [M_W-1:0] mx, my;
    mx  = {r3[0], fx_d3};
    my  = {r3[1], fy_d3};
    wx  = negx_d3 ? (M_W'(1 << FRAC_BITS) - $signed({2'b00, mx}))
                  : ($signed({2'b00, mx}) + M_W'(1 << FRAC_BITS));
    wy  = negy_d3 ? (M_W'(1 << FRAC_BITS) - $signed({2'b00, my}))
                  : ($signed({2'b00, my}) + M_W'(1 << FRAC_BITS));
    awx = wx[M_W+1] ? (M_W+2)'(-wx) : (M_W+2)'(wx);
    awy = wy[M_W+1] ? (M_W+2)'(-wy) : (M_W+2)'(wy);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_d3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      floor_u       <= fu_d3;
      floor_v       <= fv_d3;
      floor_outside <= out_d3;
      sky_u         <= awx[FRAC_BITS +: TEX_W];
      sky_v         <= awy[FRAC_BITS +: TEX_W];
    end
  end

endmodule

### rtl/pfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_div
// Pipelined restoring divider: one quotient bit per stage, several lanes
// sharing one divisor, with a side payload that travels alongside.
// ----------------------------------------------------------------------------
module pfs_div #(
  parameter int NB    = 32,
  parameter int DB    = 11,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NB-1:0]   in_num,
  input  logic [DB-1:0]              in_den,
  input  logic [PW-1:0]              in_pay,
  output logic                       out_valid,
  output logic [LANES-1:0][NB-1:0]   out_quo,
  output logic [LANES-1:0][DB-1:0]   out_rem,
  output logic [PW-1:0]              out_pay
);

  // Stage registers: dividend bits shift out at the top, quotient bits in
  logic                     vld [NB];
  logic [LANES-1:0][NB-1:0] w   [NB];
  logic [LANES-1:0][DB-1:0] rem [NB];
  logic [DB-1:0]            den [NB];
  logic [PW-1:0]            pay [NB];

  for (genvar s = 0; s < NB; s++) begin : g_stage
    logic                     v_i;
    logic [LANES-1:0][NB-1:0] w_i;
    logic [LANES-1:0][DB-1:0] r_i;
    logic [DB-1:0]            d_i;
    logic [PW-1:0]            p_i;
    logic [LANES-1:0][NB-1:0] w_n;
    logic [LANES-1:0][DB-1:0] r_n;

    // Select the stage source
    if (s == 0) begin : g_first
      assign v_i = in_valid;
      assign w_i = in_num;
      assign r_i = '0;
      assign d_i = in_den;
      assign p_i = in_pay;
    end else begin : g_rest
      assign v_i = vld[s-1];
      assign w_i = w[s-1];
      assign r_i = rem[s-1];
      assign d_i = den[s-1];
      assign p_i = pay[s-1];
    end

    // Bring down one bit, subtract where the divisor fits
    always_comb begin
      logic [DB:0] trial;
      trial = '0;
      for (int l = 0; l < LANES; l++) begin
        trial = {r_i[l], w_i[l][NB-1]};
        if (trial >= {1'b0, d_i}) begin
          r_n[l] = DB'(trial - {1'b0, d_i});
          w_n[l] = {w_i[l][NB-2:0], 1'b1};
        end else begin
          r_n[l] = trial[DB-1:0];
          w_n[l] = {w_i[l][NB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w[s]   <= w_n;
        rem[s] <= r_n;
        den[s] <= d_i;
        pay[s] <= p_i;
      end
    end
  end

  assign out_valid = vld[NB-1];
  assign out_quo   = w[NB-1];
  assign out_rem   = rem[NB-1];
  assign out_pay   = pay[NB-1];

endmodule

### rtl/pfs_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_corner
// Frustum corner sequencer: sine and cosine of two angles, computed on a
// shared multiplier, scaled by the near and far distances, plus camera x/y.
// ----------------------------------------------------------------------------
module pfs_corner import pfs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  cam_cfg_t cfg,
  output logic     busy,
  output corner_t  corners [NUM_CORNERS]
);

  localparam logic [4:0] LAST_OP = 5'(4 * 4 + NUM_CORNERS - 1);

  corner_state_t      state, state_next;
  logic [4:0]         op;
  logic               mul_en, store_en;
  logic               is_corner;
  logic [1:0]         idx, sub, ti;
  logic [2:0]         k;
  logic [15:0]        a1, a2, base, angle;
  logic [14:0]        t, x2, r;
  logic signed [15:0] trig [4];
  logic signed [17:0] ma;
  logic signed [20:0] mb;
  logic signed [38:0] p;
  logic signed [24:0] ph;
  logic [15:0]        sm, sat;

  // Decode the current operation
  assign is_corner = op[4];
  assign idx       = op[3:2];
  assign sub       = op[1:0];
  assign k         = op[2:0];
  assign ti        = {k[2], k[0]};
  assign a1        = cfg.heading - {2'b00, cfg.half_fov};
  assign a2        = cfg.heading + {2'b00, cfg.half_fov};
  assign base      = idx[1] ? a2 : a1;
  assign angle     = base + (idx[0] ? 16'd0 : 16'(QUARTER));
  assign t         = angle[14] ? 15'(QUARTER) - {1'b0, angle[13:0]} : {1'b0, angle[13:0]};
  assign ph        = p[38:TRIG_FRAC];
  assign sm        = p[29:14];
  assign sat       = (sm > 16'(QUARTER)) ? 16'(QUARTER) : sm;

  // Select multiplier operands
  always_comb begin
    if (is_corner) begin
      ma = 18'(trig[ti]);
      mb = $signed({1'b0, k[1] ? cfg.near_dist : cfg.far_dist});
    end else begin
      unique case (sub)
        2'd0: begin
          ma = $signed({3'b000, t});
          mb = $signed({6'b000000, t});
        end
        2'd1: begin
          ma = $signed({3'b000, x2});
          mb = 21'(SIN_C2);
        end
        2'd2: begin
          ma = $signed({3'b000, x2});
          mb = $signed({6'b000000, r});
        end
        default: begin
          ma = $signed({3'b000, t});
          mb = $signed({6'b000000, r});
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    if (start) begin
      state_next = CS_MUL;
    end else begin
      unique case (state)
        CS_IDLE:  state_next = CS_IDLE;
        CS_MUL:   state_next = CS_STORE;
        CS_STORE: state_next = (op == LAST_OP) ? CS_IDLE : CS_MUL;
        default:  state_next = CS_IDLE;
      endcase
    end
  end

  // State outputs
  always_comb begin
    busy     = (state != CS_IDLE);
    mul_en   = (state == CS_MUL);
    store_en = (state == CS_STORE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      op    <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        op <= '0;
      end else if (store_en) begin
        op <= op + 5'd1;
      end
    end
  end

  // Hold the product
  always_ff @(posedge clk) begin
    if (mul_en) begin
      p <= ma * mb;
    end
  end

  // Advance the sine polynomial
  always_ff @(posedge clk) begin
    if (store_en && !is_corner) begin
      unique case (sub)
        2'd0: x2 <= p[28:14];
        2'd1: r  <= 15'(SIN_C1) - p[28:14];
        2'd2: r  <= 15'(SIN_C3) - p[28:14];
        default: trig[idx] <= angle[15] ? -$signed(sat) : $signed(sat);
      endcase
    end
  end

  // Store corners; reset leaves them zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        corners[i] <= '0;
      end
    end else if (store_en && is_corner) begin
      corners[k] <= CORNER_W'(ph) +
                    CORNER_W'(k[0] ? cfg.camera_y : cfg.camera_x);
    end
  end

endmodule
